@@ src/fcr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared types and constants of the framed command receiver.
// ----------------------------------------------------------------------------
package fcr_pkg;

	localparam int MaxPayload = 5;
	localparam int StoreIdxW  = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
	localparam int NumPayloadOut = 5;

	localparam logic [7:0] StartByte   = 8'hFE;
	localparam logic [7:0] LedGroup    = 8'h40;
	localparam logic [7:0] CodeLed1Off = 8'h10;
	localparam logic [7:0] CodeLed1On  = 8'h11;
	localparam logic [7:0] CodeLed2Off = 8'h20;
	localparam logic [7:0] CodeLed2On  = 8'h21;

	typedef enum logic [2:0] {
		POS_IDLE  = 3'd0,
		POS_LEN   = 3'd1,
		POS_GROUP = 3'd2,
		POS_CODE  = 3'd3,
		POS_DATA  = 3'd4,
		POS_CHECK = 3'd5
	} pos_t;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

	typedef struct packed {
		status_t                          status;
		logic [7:0]                       length;
		logic [7:0]                       group;
		logic [7:0]                       code;
		logic [NumPayloadOut-1:0][7:0]    payload;
		logic                             led_one;
		logic                             led_two;
	} result_t;

endpackage

@@ src/framed_command_receiver_xor_check_top.sv @@
`timescale 1ns / 1ps
// A check byte is held in the input register; its result is then loaded into the result register.
// Throughput: one byte per cycle; the input register drains into the parser
// each cycle unless a result is due and the result register is still full.
// Reset: arst_n clears the frame position, header, XOR, LED flags and valid
// bits at once; the payload store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// framed_command_receiver_xor_check_top
// Byte-stream frame receiver with XOR check and LED command decode.
// ----------------------------------------------------------------------------
module framed_command_receiver_xor_check_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [1:0] status,
	output logic [7:0] length_out,
	output logic [7:0] command_group,
	output logic [7:0] command_code,
	output logic [7:0] payload_0,
	output logic [7:0] payload_1,
	output logic [7:0] payload_2,
	output logic [7:0] payload_3,
	output logic [7:0] payload_4,
	output logic       led_one_on,
	output logic       led_two_on
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             emits;
	logic             slot_ready;
	logic             advance;
	fcr_pkg::result_t result;
	fcr_pkg::result_t res_data;

	// hold the byte only when its result has nowhere to go
	assign advance  = valid_s1 && (!emits || slot_ready);
	assign rx_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready)
			byte_s1 <= rx_byte;
	end

	fcr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.emits   (emits),
		.result  (result)
	);

	fcr_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && emits),
		.load_data  (result),
		.load_ready (slot_ready),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data)
	);

	assign status        = res_data.status;
	assign length_out    = res_data.length;
	assign command_group = res_data.group;
	assign command_code  = res_data.code;
	assign payload_0     = res_data.payload[0];
	assign payload_1     = res_data.payload[1];
	assign payload_2     = res_data.payload[2];
	assign payload_3     = res_data.payload[3];
	assign payload_4     = res_data.payload[4];
	assign led_one_on    = res_data.led_one;
	assign led_two_on    = res_data.led_two;

endmodule

@@ src/fcr_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_parser
// Frame state machine, header and payload store, running XOR and LED flags.
// ----------------------------------------------------------------------------
module fcr_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	output logic              emits,
	output fcr_pkg::result_t  result
);

	fcr_pkg::pos_t pos_q, pos_d;
	logic [7:0] count_q, count_d;
	logic [7:0] length_q, length_d;
	logic [7:0] group_q, group_d;
	logic [7:0] code_q, code_d;
	logic [7:0] acc_q, acc_d;
	logic       led_one_q, led_one_d;
	logic       led_two_q, led_two_d;
	logic [7:0] store_q [fcr_pkg::MaxPayload];
	logic       too_long;
	logic       good;
	logic [7:0] count_inc;

	assign count_inc = count_q + 8'd1;
	assign too_long  = length_q > 8'(fcr_pkg::MaxPayload);
	assign good      = !too_long && (rx_byte == acc_q);
	assign emits     = (pos_q == fcr_pkg::POS_CHECK);

	// next position
	always_comb begin
		pos_d = fcr_pkg::POS_IDLE;
		case (pos_q)
			fcr_pkg::POS_LEN:   pos_d = fcr_pkg::POS_GROUP;
			fcr_pkg::POS_GROUP: pos_d = fcr_pkg::POS_CODE;
			fcr_pkg::POS_CODE:  pos_d = (length_q == 8'd0) ? fcr_pkg::POS_CHECK
			                                              : fcr_pkg::POS_DATA;
			fcr_pkg::POS_DATA:  pos_d = (count_inc >= length_q) ? fcr_pkg::POS_CHECK
			                                                   : fcr_pkg::POS_DATA;
			fcr_pkg::POS_CHECK: pos_d = fcr_pkg::POS_IDLE;
			default:            pos_d = (rx_byte == fcr_pkg::StartByte) ? fcr_pkg::POS_LEN
			                                                          : fcr_pkg::POS_IDLE;
		endcase
	end

	// datapath updates and result
	always_comb begin
		count_d   = count_q;
		length_d  = length_q;
		group_d   = group_q;
		code_d    = code_q;
		acc_d     = acc_q;
		led_one_d = led_one_q;
		led_two_d = led_two_q;
		case (pos_q)
			fcr_pkg::POS_LEN: begin
				length_d = rx_byte;
				acc_d    = rx_byte;
				count_d  = 8'd0;
			end
			fcr_pkg::POS_GROUP: begin
				group_d = rx_byte;
				acc_d   = acc_q ^ rx_byte;
			end
			fcr_pkg::POS_CODE: begin
				code_d = rx_byte;
				acc_d  = acc_q ^ rx_byte;
			end
			fcr_pkg::POS_DATA: begin
				acc_d   = acc_q ^ rx_byte;
				count_d = count_inc;
			end
			fcr_pkg::POS_CHECK: begin
				if (good && group_q == fcr_pkg::LedGroup) begin
					case (code_q)
						fcr_pkg::CodeLed1Off: led_one_d = 1'b0;
						fcr_pkg::CodeLed1On:  led_one_d = 1'b1;
						fcr_pkg::CodeLed2Off: led_two_d = 1'b0;
						fcr_pkg::CodeLed2On:  led_two_d = 1'b1;
						default:              ;
					endcase
				end
			end
			default: ;
		endcase

		if (too_long)
			result.status = fcr_pkg::ST_TOO_LONG;
		else if (!good)
			result.status = fcr_pkg::ST_MISMATCH;
		else
			result.status = fcr_pkg::ST_GOOD;
		result.length  = length_q;
		result.group   = group_q;
		result.code    = code_q;
		for (int k = 0; k < fcr_pkg::NumPayloadOut; k++) begin
			if (k < fcr_pkg::MaxPayload && 8'(k) < length_q)
				result.payload[k] = store_q[k];
			else
				result.payload[k] = 8'd0;
		end
		result.led_one = led_one_d;
		result.led_two = led_two_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= fcr_pkg::POS_IDLE;
			count_q   <= 8'd0;
			length_q  <= 8'd0;
			group_q   <= 8'd0;
			code_q    <= 8'd0;
			acc_q     <= 8'd0;
			led_one_q <= 1'b0;
			led_two_q <= 1'b0;
		end else if (step) begin
			pos_q     <= pos_d;
			count_q   <= count_d;
			length_q  <= length_d;
			group_q   <= group_d;
			code_q    <= code_d;
			acc_q     <= acc_d;
			led_one_q <= led_one_d;
			led_two_q <= led_two_d;
		end
	end

	// store only the first bytes that fit; the rest still enter the XOR
	always_ff @(posedge clk) begin
		if (step && pos_q == fcr_pkg::POS_DATA &&
		    count_q < 8'(fcr_pkg::MaxPayload))
			store_q[count_q[fcr_pkg::StoreIdxW-1:0]] <= rx_byte;
	end

endmodule

@@ src/fcr_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_out_reg
// Result register; holds one finished result until its transfer.
// ----------------------------------------------------------------------------
module fcr_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  fcr_pkg::result_t  load_data,
	output logic              load_ready,
	output logic              res_valid,
	input  logic              res_ready,
	output fcr_pkg::result_t  res_data
);

	logic             valid_q;
	fcr_pkg::result_t data_q;

	assign load_ready = !valid_q || res_ready;
	assign res_valid  = valid_q;
	assign res_data   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_ready)
			data_q <= load_data;
	end

endmodule

@@ verif/tb_framed_command_receiver_xor_check_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_command_receiver_xor_check_top
// Self-checking bench for the framed command receiver. Byte frames (good,
// corrupted, oversized, truncated) mixed with line noise are pushed through
// the rx channel with random gaps. A local frame parser predicts each report
// and the monitor compares it field by field under random backpressure.
// ----------------------------------------------------------------------------
module tb_framed_command_receiver_xor_check_top;

	localparam int NumRxBytes = 1450;
	localparam int CycleLimit = 300000;
	localparam int LongHoldAt = 30;
	localparam int LongHoldCycles = 300;

	typedef struct {
		logic [7:0] value;
		bit         wait_drain;
	} rx_item_t;

	logic       clk;
	logic       arst_n;
	logic       rx_valid = 1'b0;
	logic       rx_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       res_valid;
	logic       res_ready = 1'b0;
	logic [1:0] status;
	logic [7:0] length_out;
	logic [7:0] command_group;
	logic [7:0] command_code;
	logic [7:0] payload_0;
	logic [7:0] payload_1;
	logic [7:0] payload_2;
	logic [7:0] payload_3;
	logic [7:0] payload_4;
	logic       led_one_on;
	logic       led_two_on;

	framed_command_receiver_xor_check_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.rx_byte      (rx_byte),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.status       (status),
		.length_out   (length_out),
		.command_group(command_group),
		.command_code (command_code),
		.payload_0    (payload_0),
		.payload_1    (payload_1),
		.payload_2    (payload_2),
		.payload_3    (payload_3),
		.payload_4    (payload_4),
		.led_one_on   (led_one_on),
		.led_two_on   (led_two_on)
	);

	rx_item_t          rx_items [$];
	fcr_pkg::result_t  expected_reports [$];
	int       fail_count = 0;
	int       cycle_count = 0;
	int       bytes_queued = 0;
	bit       drain_next = 1'b0;
	bit       calm = 1'b0;

	// parser state of the prediction
	fcr_pkg::pos_t frame_pos = fcr_pkg::POS_IDLE;
	logic [7:0] taken_count = 8'h00;
	logic [7:0] frame_len = 8'h00;
	logic [7:0] group_reg = 8'h00;
	logic [7:0] code_reg = 8'h00;
	logic [7:0] payload_mem [fcr_pkg::MaxPayload];
	logic [7:0] xor_sum = 8'h00;
	logic       led_one = 1'b0;
	logic       led_two = 1'b0;

	int  send_gap = 0;
	bit  send_busy;
	rx_item_t send_item;
	int  recv_stall = 0;
	int  recv_hold = 0;
	int  reports_seen = 0;
	bit  long_hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < fcr_pkg::MaxPayload; i++) payload_mem[i] = 8'h00;
	end

	function automatic int pick_gap();
		int r;
		if ($urandom_range(0, 63) == 0) calm = !calm;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_byte(input logic [7:0] b);
		rx_item_t it;
		it.value = b;
		it.wait_drain = drain_next;
		drain_next = 1'b0;
		rx_items.push_back(it);
		bytes_queued++;
	endtask

	// fill < 0 gives random payload bytes, otherwise every byte is fill
	task automatic add_frame(input int len, input logic [7:0] grp, input logic [7:0] cod,
			input int fill, input bit corrupt);
		logic [7:0] sum;
		logic [7:0] d;
		sum = len[7:0] ^ grp ^ cod;
		add_byte(fcr_pkg::StartByte);
		add_byte(len[7:0]);
		add_byte(grp);
		add_byte(cod);
		for (int i = 0; i < len; i++) begin
			d = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
			sum ^= d;
			add_byte(d);
		end
		if (corrupt) sum ^= 8'($urandom_range(1, 255));
		add_byte(sum);
	endtask

	task automatic parse_rx_byte(input logic [7:0] b);
		fcr_pkg::result_t r;
		case (frame_pos)
			fcr_pkg::POS_LEN: begin
				frame_len = b;
				xor_sum = b;
				taken_count = 8'h00;
				frame_pos = fcr_pkg::POS_GROUP;
			end
			fcr_pkg::POS_GROUP: begin
				group_reg = b;
				xor_sum ^= b;
				frame_pos = fcr_pkg::POS_CODE;
			end
			fcr_pkg::POS_CODE: begin
				code_reg = b;
				xor_sum ^= b;
				if (frame_len == 8'h00) frame_pos = fcr_pkg::POS_CHECK;
				else frame_pos = fcr_pkg::POS_DATA;
			end
			fcr_pkg::POS_DATA: begin
				if (taken_count < fcr_pkg::MaxPayload) payload_mem[taken_count] = b;
				xor_sum ^= b;
				taken_count = taken_count + 8'h01;
				if (taken_count >= frame_len) frame_pos = fcr_pkg::POS_CHECK;
			end
			fcr_pkg::POS_CHECK: begin
				frame_pos = fcr_pkg::POS_IDLE;
				if (frame_len > fcr_pkg::MaxPayload) begin
					r.status = fcr_pkg::ST_TOO_LONG;
				end else if (b != xor_sum) begin
					r.status = fcr_pkg::ST_MISMATCH;
				end else begin
					r.status = fcr_pkg::ST_GOOD;
					if (group_reg == fcr_pkg::LedGroup) begin
						if (code_reg == fcr_pkg::CodeLed1Off) led_one = 1'b0;
						else if (code_reg == fcr_pkg::CodeLed1On) led_one = 1'b1;
						else if (code_reg == fcr_pkg::CodeLed2Off) led_two = 1'b0;
						else if (code_reg == fcr_pkg::CodeLed2On) led_two = 1'b1;
					end
				end
				r.length = frame_len;
				r.group = group_reg;
				r.code = code_reg;
				for (int k = 0; k < fcr_pkg::NumPayloadOut; k++) begin
					if (k < fcr_pkg::MaxPayload && k < frame_len)
						r.payload[k] = payload_mem[k];
					else r.payload[k] = 8'h00;
				end
				r.led_one = led_one;
				r.led_two = led_two;
				expected_reports.push_back(r);
			end
			default: begin
				if (b == fcr_pkg::StartByte) frame_pos = fcr_pkg::POS_LEN;
				else frame_pos = fcr_pkg::POS_IDLE;
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			fail_count++;
			if (fail_count <= 10)
				$display("report %0d %s: expected %02h, got %02h", reports_seen, name,
					exp_v, act_v);
		end
	endtask

	task automatic check_report();
		fcr_pkg::result_t e;
		if (expected_reports.size() == 0) begin
			fail_count++;
			if (fail_count <= 10) $display("report %0d arrived with none expected", reports_seen);
			return;
		end
		e = expected_reports.pop_front();
		check_field("status", 8'(e.status), 8'(status));
		check_field("length_out", e.length, length_out);
		check_field("command_group", e.group, command_group);
		check_field("command_code", e.code, command_code);
		check_field("payload_0", e.payload[0], payload_0);
		check_field("payload_1", e.payload[1], payload_1);
		check_field("payload_2", e.payload[2], payload_2);
		check_field("payload_3", e.payload[3], payload_3);
		check_field("payload_4", e.payload[4], payload_4);
		check_field("led_one_on", 8'(e.led_one), 8'(led_one_on));
		check_field("led_two_on", 8'(e.led_two), 8'(led_two_on));
	endtask

	// driver: pops pending bytes, holds each until its transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
			rx_byte <= 8'h00;
			send_gap = 0;
		end else begin
			send_busy = rx_valid;
			if (rx_valid && rx_ready) begin
				parse_rx_byte(rx_byte);
				send_busy = 1'b0;
				send_gap = pick_gap();
			end
			if (!send_busy) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (rx_items.size() > 0 &&
						(!rx_items[0].wait_drain || expected_reports.size() == 0)) begin
					send_item = rx_items.pop_front();
					rx_byte <= send_item.value;
					send_busy = 1'b1;
				end
			end
			rx_valid <= send_busy;
		end
	end

	// monitor: checks each report transfer and throttles res_ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			recv_stall = 0;
			recv_hold = 0;
		end else begin
			if (res_valid && res_ready) begin
				check_report();
				reports_seen++;
				recv_stall = pick_gap();
				if (reports_seen == LongHoldAt && !long_hold_done) begin
					recv_hold = LongHoldCycles;
					long_hold_done = 1'b1;
				end
			end else if (!res_valid && recv_stall == 0 && $urandom_range(0, 7) == 0) begin
				recv_stall = pick_gap();
			end
			if (recv_hold > 0) begin
				recv_hold--;
				res_ready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int r;
		int len;
		logic [7:0] grp;
		logic [7:0] cod;
		bit mid_drain_done;

		mid_drain_done = 1'b0;

		// directed: noise, zero-length LED commands, start byte as payload,
		// check mismatch, oversized frame with extreme payload
		add_byte(8'h00);
		add_frame(0, fcr_pkg::LedGroup, fcr_pkg::CodeLed1On, -1, 1'b0);
		add_frame(1, fcr_pkg::LedGroup, fcr_pkg::CodeLed2On, int'(fcr_pkg::StartByte), 1'b0);
		add_frame(0, fcr_pkg::LedGroup, fcr_pkg::CodeLed1Off, -1, 1'b1);
		add_frame(fcr_pkg::MaxPayload + 1, fcr_pkg::LedGroup, fcr_pkg::CodeLed2Off, 255, 1'b0);
		add_byte(8'hFF);

		drain_next = 1'b1;
		while (bytes_queued < NumRxBytes) begin
			if (!mid_drain_done && bytes_queued > NumRxBytes / 2) begin
				drain_next = 1'b1;
				mid_drain_done = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 75) begin
				r = $urandom_range(0, 99);
				if (r < 70) len = $urandom_range(0, fcr_pkg::MaxPayload);
				else if (r < 92) len = $urandom_range(fcr_pkg::MaxPayload + 1, 9);
				else if (r < 98) len = $urandom_range(10, 40);
				else len = $urandom_range(200, 255);
				grp = ($urandom_range(0, 1) == 0) ? fcr_pkg::LedGroup
				                                 : 8'($urandom_range(0, 255));
				case ($urandom_range(0, 9))
					0: cod = fcr_pkg::CodeLed1Off;
					1: cod = fcr_pkg::CodeLed1On;
					2: cod = fcr_pkg::CodeLed2Off;
					3: cod = fcr_pkg::CodeLed2On;
					4: cod = fcr_pkg::CodeLed1On;
					5: cod = fcr_pkg::CodeLed2On;
					default: cod = 8'($urandom_range(0, 255));
				endcase
				add_frame(len, grp, cod, -1, $urandom_range(0, 4) == 0);
			end else if (r < 90) begin
				repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
			end else begin
				// truncated frame: following bytes are taken as its tail
				add_byte(fcr_pkg::StartByte);
				repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
			end
		end

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (rx_items.size() > 0 || rx_valid || expected_reports.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (expected_reports.size() > 0) begin
			fail_count++;
			$display("%0d reports never arrived", expected_reports.size());
		end
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/fcr_pkg.sv
src/fcr_parser.sv
src/fcr_out_reg.sv
src/framed_command_receiver_xor_check_top.sv
verif/tb_framed_command_receiver_xor_check_top.sv
